/* src/qtl_pkg.sv */
// qtl_pkg: shared types, codes and constants of the quoted token lexer.
// Used by qtl_front, qtl_back and quoted_token_lexer; no dependencies.
package qtl_pkg;

  // longest kept token is MAX_TOKEN-1 bytes
  localparam int MAX_TOKEN = 128;
  localparam int LEN_W     = $clog2(MAX_TOKEN);

  // queue sizes between front, back and the result side
  localparam int OPQ_DEPTH  = 4;
  localparam int OPQ_AW     = $clog2(OPQ_DEPTH);
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);

  localparam logic [30:0] VALUE_MAX = 31'h7FFF_FFFF;

  // character constants
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_LN    = 8'h6E;
  localparam logic [7:0] CH_LT    = 8'h74;

  // operations handed from front to back
  typedef enum logic [1:0] {
    OP_KEEP,
    OP_END,
    OP_EOS
  } op_code_t;

  typedef struct packed {
    op_code_t   code;
    logic [7:0] ch;
  } op_t;

  // result kinds
  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_END  = 2'd1,
    KIND_EOS  = 2'd2
  } kind_t;

  // token classes
  typedef enum logic [1:0] {
    CLS_NUMBER = 2'd0,
    CLS_SYMBOL = 2'd1,
    CLS_NAME   = 2'd2
  } tok_class_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  out_char;
    tok_class_t  token_class;
    logic [30:0] number_value;
    logic [6:0]  token_length;
    logic        truncated;
    logic        last;
  } result_t;

  // handshake between front op queue and back
  typedef struct packed {
    logic valid;
    op_t  op;
  } op_link_t;

endpackage

/* src/qtl_front.sv */
// qtl_front: takes input bytes, tracks quote and escape state, and queues
// one operation per byte that has an effect. Depends on qtl_pkg.
module qtl_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [7:0]          in_byte,
  input  logic                end_of_input,
  output qtl_pkg::op_link_t   link,
  input  logic                take
);

  logic                     in_quotes;
  logic                     in_quotes_next;
  logic                     escape_pending;
  logic                     escape_pending_next;
  qtl_pkg::op_t             op_in;
  logic                     gen;
  logic                     accept;
  logic                     wr_en;
  logic                     rd_en;
  qtl_pkg::op_t             mem [qtl_pkg::OPQ_DEPTH];
  logic [qtl_pkg::OPQ_AW-1:0] wr_ptr;
  logic [qtl_pkg::OPQ_AW-1:0] rd_ptr;
  logic [qtl_pkg::OPQ_AW:0]   count;

  assign full   = (count == (qtl_pkg::OPQ_AW+1)'(qtl_pkg::OPQ_DEPTH));
  assign accept = push && !full;
  assign wr_en  = accept && gen;
  assign rd_en  = take && (count != '0);

  // classify the incoming byte
  always_comb begin
    op_in.code          = qtl_pkg::OP_KEEP;
    op_in.ch            = in_byte;
    gen                 = 1'b0;
    in_quotes_next      = in_quotes;
    escape_pending_next = escape_pending;
    if (end_of_input) begin
      op_in.code          = qtl_pkg::OP_EOS;
      gen                 = 1'b1;
      in_quotes_next      = 1'b0;
      escape_pending_next = 1'b0;
    end else if (in_byte == qtl_pkg::CH_NL) begin
      op_in.code          = qtl_pkg::OP_END;
      gen                 = 1'b1;
      in_quotes_next      = 1'b0;
      escape_pending_next = 1'b0;
    end else if (escape_pending) begin
      escape_pending_next = 1'b0;
      if (in_byte == qtl_pkg::CH_LN) begin
        op_in.ch = qtl_pkg::CH_NL;
        gen      = 1'b1;
      end else if (in_byte == qtl_pkg::CH_LT) begin
        op_in.ch = qtl_pkg::CH_TAB;
        gen      = 1'b1;
      end else if (in_byte == qtl_pkg::CH_BSL) begin
        gen = 1'b1;
      end
    end else if ((in_byte == qtl_pkg::CH_SPACE || in_byte == qtl_pkg::CH_TAB)
                 && !in_quotes) begin
      op_in.code = qtl_pkg::OP_END;
      gen        = 1'b1;
    end else if (in_byte == qtl_pkg::CH_QUOTE) begin
      in_quotes_next = !in_quotes;
    end else if (in_byte == qtl_pkg::CH_BSL) begin
      escape_pending_next = 1'b1;
    end else begin
      gen = 1'b1;
    end
  end

  // advance quote and escape state on each beat
  always_ff @(posedge clk) begin
    if (rst) begin
      in_quotes      <= 1'b0;
      escape_pending <= 1'b0;
    end else if (accept) begin
      in_quotes      <= in_quotes_next;
      escape_pending <= escape_pending_next;
    end
  end

  // op queue storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= op_in;
    end
  end

  // op queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (qtl_pkg::OPQ_AW+1)'(wr_en) - (qtl_pkg::OPQ_AW+1)'(rd_en);
    end
  end

  assign link.valid = (count != '0);
  assign link.op    = mem[rd_ptr];

endmodule

/* src/qtl_back.sv */
// qtl_back: carries out queued operations on the token state and queues
// the results for the output side. Depends on qtl_pkg.
module qtl_back (
  input  logic                clk,
  input  logic                rst,
  input  qtl_pkg::op_link_t   link,
  output logic                take,
  output logic                empty,
  input  logic                pop,
  output qtl_pkg::result_t    res_out
);

  logic [qtl_pkg::LEN_W-1:0]  kept_length;
  logic [qtl_pkg::LEN_W-1:0]  kept_length_next;
  qtl_pkg::tok_class_t        first_class;
  qtl_pkg::tok_class_t        first_class_next;
  logic                       digit_run_open;
  logic                       digit_run_open_next;
  logic [30:0]                running_value;
  logic [30:0]                running_value_next;
  logic                       cut_off;
  logic                       cut_off_next;
  logic                       eos_phase;
  logic                       eos_phase_next;

  qtl_pkg::result_t           res;
  logic                       emit;
  logic                       go;
  logic                       is_digit;
  logic                       is_alpha;
  logic                       run_open;
  logic [34:0]                prod;
  logic [7:0]                 len8;
  logic                       token_open;

  qtl_pkg::result_t           mem [qtl_pkg::OUTQ_DEPTH];
  logic [qtl_pkg::OUTQ_AW-1:0] wr_ptr;
  logic [qtl_pkg::OUTQ_AW-1:0] rd_ptr;
  logic [qtl_pkg::OUTQ_AW:0]   count;
  logic                        wr_en;
  logic                        rd_en;

  assign go         = link.valid &&
                      (count != (qtl_pkg::OUTQ_AW+1)'(qtl_pkg::OUTQ_DEPTH));
  assign is_digit   = (link.op.ch >= qtl_pkg::CH_0) && (link.op.ch <= qtl_pkg::CH_9);
  assign is_alpha   = ((link.op.ch >= qtl_pkg::CH_UA) && (link.op.ch <= qtl_pkg::CH_UZ)) ||
                      ((link.op.ch >= qtl_pkg::CH_LA) && (link.op.ch <= qtl_pkg::CH_LZ));
  assign token_open = (kept_length != '0);
  assign run_open   = token_open ? digit_run_open : is_digit;
  assign prod       = {1'b0, running_value, 3'b000} + {3'b000, running_value, 1'b0}
                      + {31'd0, link.op.ch[3:0] - 4'd0};
  assign len8       = 8'(kept_length);

  // execute one operation
  always_comb begin
    kept_length_next    = kept_length;
    first_class_next    = first_class;
    digit_run_open_next = digit_run_open;
    running_value_next  = running_value;
    cut_off_next        = cut_off;
    eos_phase_next      = eos_phase;
    emit                = 1'b0;
    take                = 1'b0;

    res.kind         = qtl_pkg::KIND_END;
    res.out_char     = '0;
    res.token_class  = first_class;
    res.number_value = (first_class == qtl_pkg::CLS_NUMBER) ? running_value : '0;
    res.token_length = len8[6:0];
    res.truncated    = cut_off;
    res.last         = 1'b1;

    case (link.op.code)
      qtl_pkg::OP_KEEP: begin
        take = 1'b1;
        if (kept_length >= qtl_pkg::LEN_W'(qtl_pkg::MAX_TOKEN - 1)) begin
          cut_off_next = 1'b1;
        end else begin
          emit             = 1'b1;
          res.kind         = qtl_pkg::KIND_BYTE;
          res.out_char     = link.op.ch;
          res.token_class  = qtl_pkg::CLS_NUMBER;
          res.number_value = '0;
          res.token_length = '0;
          res.truncated    = 1'b0;
          if (!token_open) begin
            if (is_digit) begin
              first_class_next = qtl_pkg::CLS_NUMBER;
            end else if (is_alpha) begin
              first_class_next = qtl_pkg::CLS_NAME;
            end else begin
              first_class_next = qtl_pkg::CLS_SYMBOL;
            end
          end
          digit_run_open_next = run_open;
          if (run_open) begin
            if (is_digit) begin
              // saturate at the largest 31-bit value
              if (prod > {4'd0, qtl_pkg::VALUE_MAX}) begin
                running_value_next = qtl_pkg::VALUE_MAX;
              end else begin
                running_value_next = prod[30:0];
              end
            end else begin
              digit_run_open_next = 1'b0;
            end
          end
          kept_length_next = kept_length + 1'b1;
        end
      end
      qtl_pkg::OP_END: begin
        take = 1'b1;
        emit = token_open;
        kept_length_next    = '0;
        first_class_next    = qtl_pkg::CLS_NUMBER;
        digit_run_open_next = 1'b0;
        running_value_next  = '0;
        cut_off_next        = 1'b0;
      end
      qtl_pkg::OP_EOS: begin
        emit = 1'b1;
        kept_length_next    = '0;
        first_class_next    = qtl_pkg::CLS_NUMBER;
        digit_run_open_next = 1'b0;
        running_value_next  = '0;
        cut_off_next        = 1'b0;
        if (!eos_phase && token_open) begin
          // flush the pending token first, keep the op for the stream end
          res.last       = 1'b0;
          eos_phase_next = 1'b1;
        end else begin
          take             = 1'b1;
          eos_phase_next   = 1'b0;
          res.kind         = qtl_pkg::KIND_EOS;
          res.token_class  = qtl_pkg::CLS_NUMBER;
          res.number_value = '0;
          res.token_length = '0;
          res.truncated    = 1'b0;
        end
      end
      default: begin
        take = 1'b1;
      end
    endcase

    if (!go) begin
      take = 1'b0;
      emit = 1'b0;
    end
  end

  // hold token state until an op is carried out
  always_ff @(posedge clk) begin
    if (rst) begin
      kept_length    <= '0;
      first_class    <= qtl_pkg::CLS_NUMBER;
      digit_run_open <= 1'b0;
      running_value  <= '0;
      cut_off        <= 1'b0;
      eos_phase      <= 1'b0;
    end else if (go) begin
      kept_length    <= kept_length_next;
      first_class    <= first_class_next;
      digit_run_open <= digit_run_open_next;
      running_value  <= running_value_next;
      cut_off        <= cut_off_next;
      eos_phase      <= eos_phase_next;
    end
  end

  assign wr_en = emit;
  assign rd_en = pop && (count != '0);

  // result queue storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= res;
    end
  end

  // result queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (qtl_pkg::OUTQ_AW+1)'(wr_en) - (qtl_pkg::OUTQ_AW+1)'(rd_en);
    end
  end

  assign empty   = (count == '0);
  assign res_out = mem[rd_ptr];

endmodule

/* src/quoted_token_lexer.sv */
// quoted_token_lexer: top level of the lexer, front classifier plus back
// token engine. Depends on qtl_pkg, qtl_front and qtl_back.
//
//   channel | handshake        | beat carries
//   --------+------------------+---------------------------------------------
//   input   | push / full      | in_byte, end_of_input
//   result  | empty / pop      | kind, out_char, token_class, number_value,
//           |                  | token_length, truncated, last
//
// One byte is taken per cycle while full is low; its op is registered in the
// op queue, its result in the result queue. The back engine sets the rate:
// one result per cycle unless stalled; end of stream first flushes any open token.
// Synchronous reset empties both four-entry queues and clears all state.
// full rises when four ops wait for the back engine; the back engine stalls
// while four results wait to be popped.
module quoted_token_lexer (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  input  logic        end_of_input,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind,
  output logic [7:0]  out_char,
  output logic [1:0]  token_class,
  output logic [30:0] number_value,
  output logic [6:0]  token_length,
  output logic        truncated,
  output logic        last
);

  qtl_pkg::op_link_t link;
  logic              take;
  qtl_pkg::result_t  res;

  // classify bytes and queue ops
  qtl_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .in_byte      (in_byte),
    .end_of_input (end_of_input),
    .link         (link),
    .take         (take)
  );

  // run the token engine and queue results
  qtl_back u_back (
    .clk     (clk),
    .rst     (rst),
    .link    (link),
    .take    (take),
    .empty   (empty),
    .pop     (pop),
    .res_out (res)
  );

  // drive result fields
  assign kind         = res.kind;
  assign out_char     = res.out_char;
  assign token_class  = res.token_class;
  assign number_value = res.number_value;
  assign token_length = res.token_length;
  assign truncated    = res.truncated;
  assign last         = res.last;

endmodule
